>>> hdl/fhpa_pkg.sv
`default_nettype none

package fhpa_pkg;

	// Request kinds carried on s_tuser
	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_TRY     = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NONE      = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam int HANDLE_W = 6;
	localparam int STATUS_W = 2;
	localparam int KIND_W   = 2;

	// Request held while its memory reads are in flight
	typedef struct packed {
		logic [KIND_W-1:0]   req_type;
		logic [HANDLE_W-1:0] handle;
	} req_t;

endpackage

`default_nettype wire

>>> hdl/fifo_handle_pool_allocator_unit.sv
`default_nettype none

// Handle pool allocator. Each request (s_tuser = kind: allocate, try-allocate
// or release; s_tdata = handle to release) gives exactly one result on the m
// side: granted handle and status (ok, no released handle, invalid release,
// pool exhausted). Allocate reuses the oldest released handle, else issues the
// next never-used one. Released handles sit in a FIFO held in a RAM; the
// in-use bitmap is a second RAM, and an entry at or above the fresh counter
// reads as free, so no clearing pass is needed after reset. A request passes
// through the registered RAM reads, then a step that decides and writes back.
// Requests are handled one at a time; the next one is taken while a result
// still waits in the output register.
module fifo_handle_pool_allocator_unit
	import fhpa_pkg::*;
#(
	parameter int unsigned NUM_HANDLES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [5:0] handle, [7:6] zero
	input  wire logic [1:0] s_tuser,   // [1:0] req_type
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata    // [5:0] granted_handle, [7:6] status
);

	localparam int HW = $clog2(NUM_HANDLES);
	localparam int CW = $clog2(NUM_HANDLES + 1);
	localparam logic [HW-1:0] LAST_POS = HW'(NUM_HANDLES - 1);
	localparam logic [CW-1:0] POOL_SIZE = CW'(NUM_HANDLES);

	// control state
	logic          s1_valid_q;
	req_t          req_s1;
	logic [HW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q, fresh_q;
	logic          out_valid_q;
	logic [HANDLE_W-1:0] out_granted_q;
	logic [STATUS_W-1:0] out_status_q;

	// memory ports
	logic          q_we, map_we, map_wd, map_rd;
	logic [HW-1:0] q_rd, map_wa;
	logic          accept, done;

	logic [HW+HANDLE_W-1:0] hin_ext, hs1_ext;
	logic [HW-1:0]          hin_idx, hs1_idx;
	logic                   in_use;

	logic [HW-1:0]       g;
	logic [HW+HANDLE_W-1:0] g_ext;
	logic [STATUS_W-1:0] st;
	logic                pop, push, fresh_inc;

	assign accept  = s_tvalid && s_tready;
	assign s_tready = !s1_valid_q;
	assign done    = s1_valid_q && (!out_valid_q || m_tready);

	assign hin_ext = {{HW{1'b0}}, s_tdata[HANDLE_W-1:0]};
	assign hin_idx = hin_ext[HW-1:0];
	assign hs1_ext = {{HW{1'b0}}, req_s1.handle};
	assign hs1_idx = hs1_ext[HW-1:0];

	// free queue: read at head on accept, written at tail on release
	fhpa_ram #(.WIDTH(HW), .DEPTH(NUM_HANDLES)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (hs1_idx),
		.re    (accept),
		.raddr (head_q),
		.rdata (q_rd)
	);

	// in-use bitmap: read at the released handle on accept
	fhpa_ram #(.WIDTH(1), .DEPTH(NUM_HANDLES)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_wa),
		.wdata (map_wd),
		.re    (accept),
		.raddr (hin_idx),
		.rdata (map_rd)
	);

	// entries at or above the fresh counter were never written: free
	assign in_use = ({{CW{1'b0}}, req_s1.handle} < {{HANDLE_W{1'b0}}, fresh_q}) && map_rd;

	// decide and write back
	always_comb begin
		g         = '0;
		st        = ST_OK;
		pop       = 1'b0;
		push      = 1'b0;
		fresh_inc = 1'b0;
		map_we    = 1'b0;
		map_wa    = hs1_idx;
		map_wd    = 1'b0;
		case (req_s1.req_type)
			REQ_ALLOC, REQ_TRY: begin
				if (count_q != '0) begin
					g      = q_rd;
					pop    = 1'b1;
					map_we = 1'b1;
					map_wa = q_rd;
					map_wd = 1'b1;
				end else if (req_s1.req_type == REQ_TRY) begin
					st = ST_NONE;
				end else if (fresh_q < POOL_SIZE) begin
					g         = fresh_q[HW-1:0];
					fresh_inc = 1'b1;
					map_we    = 1'b1;
					map_wa    = fresh_q[HW-1:0];
					map_wd    = 1'b1;
				end else begin
					st = ST_EXHAUSTED;
				end
			end
			REQ_RELEASE: begin
				if (in_use) begin
					map_we = 1'b1;
					push   = 1'b1;
				end else begin
					st = ST_INVALID;
				end
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
		map_we = map_we && done;
	end

	assign q_we  = push && done;
	assign g_ext = {{HANDLE_W{1'b0}}, g};

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type <= s_tuser;
			req_s1.handle   <= s_tdata[HANDLE_W-1:0];
		end
	end

	// queue pointers, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
		end else if (done) begin
			if (pop) begin
				head_q  <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (push) begin
				tail_q  <= (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (fresh_inc) begin
				fresh_q <= fresh_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_granted_q <= g_ext[HANDLE_W-1:0];
			out_status_q  <= st;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_status_q, out_granted_q};

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= POOL_SIZE)
		else $error("free queue count beyond pool size");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= POOL_SIZE)
		else $error("fresh counter beyond pool size");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == tail_q)
		else $error("empty free queue with head and tail apart");

	a_queued_fits: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fresh_q)
		else $error("more handles queued than ever issued");

	a_reuse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && pop |=> m_tvalid && m_tdata[7:6] == ST_OK)
		else $error("reuse from free queue did not report ok");

endmodule

`default_nettype wire

>>> hdl/fhpa_ram.sv
`default_nettype none

module fhpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read that holds when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
